// ----- rtl/fpa_pkg.sv -----
// Package for the fit placement allocator: codes, fixed field widths and the
// scan control struct. No dependencies; imported by fpa_scan and the top level.
package fpa_pkg;

  // Fixed widths of the item and result fields and of the registers.
  localparam int FUNC_W   = 1;
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PLACED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;

  // Placement policies.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 1'b1;

  // Control from the sequencer to the candidate evaluator.
  typedef struct packed {
    logic clear;   // a new request starts; forget the previous pick
    logic sample;  // memory read data is valid this cycle
  } scan_ctl_t;

endpackage

// ----- rtl/fpa_mem.sv -----
// Partition table memory: one word per partition holding the taken mark and
// the size. One write port, one read port with registered read data.
module fpa_mem #(
  parameter int DEPTH     = 16,
  parameter int ADDR_W    = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [SIZE_BITS-1:0] wr_size,
  input  logic                 wr_taken,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [SIZE_BITS-1:0] rd_size,
  output logic                 rd_taken
);

  logic [SIZE_BITS:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_taken, wr_size};
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    {rd_taken, rd_size} <= mem[rd_addr];
  end

endmodule

// ----- rtl/fpa_scan.sv -----
// Candidate evaluator: in each cycle with ctl.sample set, looks at one partition
// from the table memory and keeps the pick for the active policy. Uses fpa_pkg.
module fpa_scan
  import fpa_pkg::*;
#(
  parameter int ADDR_W    = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctl_t            ctl,
  input  logic [POLICY_W-1:0]  policy,
  input  logic [AMOUNT_W-1:0]  want,
  input  logic [SIZE_BITS-1:0] rd_size,
  input  logic                 rd_taken,
  input  logic [ADDR_W-1:0]    rd_idx,
  output logic                 found,
  output logic [ADDR_W-1:0]    pick_idx,
  output logic [SIZE_BITS-1:0] pick_size
);

  localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  logic [CMP_W-1:0] best;
  logic [CMP_W-1:0] left;
  logic             fits;
  logic             better;
  logic             take;

  // A free partition that is large enough is a candidate; best and worst fit
  // replace the pick only on a strictly better leftover, so ties keep the
  // lowest index. First and next fit keep the first candidate in scan order.
  always_comb begin
    fits = !rd_taken && (CMP_W'(rd_size) >= CMP_W'(want));
    left = CMP_W'(rd_size) - CMP_W'(want);
    case (policy)
      POL_BEST:  better = left < best;
      POL_WORST: better = left > best;
      default:   better = 1'b0;
    endcase
    take = ctl.sample && fits && (!found || better);
  end

  // Found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // Pick payload.
  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx  <= rd_idx;
      pick_size <= rd_size;
      best      <= left;
    end
  end

endmodule

// ----- rtl/fit_placement_allocator.sv -----
// Top level of the fit placement allocator: sequencer, configuration
// registers and result register. Uses fpa_pkg, fpa_mem and fpa_scan.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_stall      func, part_index, amount
//   result   out        result_valid / result_stall  status, chosen_index
//   config   in         cfg_write_en                 cfg_index, cfg_data
//
// A load or a zero count goes straight to the result register. Any other request
// scans the active partitions through the one read port, one partition per cycle,
// and a placement then marks the pick taken before the result register loads.
// Reset leaves the taken marks; only loads clear them. Sizes are undefined until
// loaded. One item is in work at a time; the next item is accepted in the cycle
// after the result register loads, even while that beat waits under result_stall.
module fit_placement_allocator
  import fpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [INDEX_W-1:0]   part_index,
  input  logic [AMOUNT_W-1:0]  amount,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [INDEX_W-1:0]   chosen_index,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam int ADDR_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [POLICY_W-1:0]  policy;
  logic [COUNT_W-1:0]   partition_count;
  logic [ADDR_W-1:0]    rover;
  logic [AMOUNT_W-1:0]  want;
  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     n_cur;
  logic [CNT_W-1:0]     issued;
  logic [ADDR_W-1:0]    scan_addr;
  logic [ADDR_W-1:0]    scan_start;
  logic [ADDR_W-1:0]    scan_addr_next;
  logic [CNT_W-1:0]     addr_inc;
  logic                 pend;
  logic [ADDR_W-1:0]    pend_idx;
  logic [STATUS_W-1:0]  res_status;
  logic [INDEX_W-1:0]   res_index;
  logic                 accept;
  logic                 slot_free;
  logic                 load_in_table;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [SIZE_BITS-1:0] mem_wsize;
  logic                 mem_wtaken;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_taken;
  logic                 found;
  logic [ADDR_W-1:0]    pick_idx;
  logic [SIZE_BITS-1:0] pick_size;
  logic [CNT_W-1:0]     pick_inc;
  scan_ctl_t            scan_ctl;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign slot_free  = !result_valid || !result_stall;

  // Active count, clipped to the table depth, and the scan starting point.
  always_comb begin
    if (32'(partition_count) > MAX_PARTITIONS) begin
      n_act = CNT_W'(MAX_PARTITIONS);
    end else begin
      n_act = CNT_W'(partition_count);
    end
    if (policy == POL_NEXT && (32'(rover) < 32'(n_act))) begin
      scan_start = rover;
    end else begin
      scan_start = '0;
    end
    addr_inc = CNT_W'(scan_addr) + CNT_W'(1);
    scan_addr_next = (addr_inc >= n_cur) ? '0 : ADDR_W'(addr_inc);
    pick_inc = CNT_W'(pick_idx) + CNT_W'(1);
    load_in_table = (32'(part_index) < MAX_PARTITIONS);
  end

  // Memory write port: a load at acceptance, or the taken mark of the pick.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pick_idx;
    mem_wsize  = pick_size;
    mem_wtaken = 1'b1;
    if (accept && func == FUNC_LOAD) begin
      mem_we     = load_in_table;
      mem_waddr  = ADDR_W'(part_index);
      mem_wsize  = SIZE_BITS'(amount);
      mem_wtaken = 1'b0;
    end else if (state == S_MARK) begin
      mem_we = 1'b1;
    end
  end

  assign scan_ctl.clear  = accept && func == FUNC_REQUEST;
  assign scan_ctl.sample = pend;

  fpa_mem #(
    .DEPTH     (MAX_PARTITIONS),
    .ADDR_W    (ADDR_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_size  (mem_wsize),
    .wr_taken (mem_wtaken),
    .rd_addr  (scan_addr),
    .rd_size  (rd_size),
    .rd_taken (rd_taken)
  );

  fpa_scan #(
    .ADDR_W    (ADDR_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .policy    (policy),
    .want      (want),
    .rd_size   (rd_size),
    .rd_taken  (rd_taken),
    .rd_idx    (pend_idx),
    .found     (found),
    .pick_idx  (pick_idx),
    .pick_size (pick_size)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy          <= POL_FIRST;
      partition_count <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_POLICY: policy          <= cfg_data[POLICY_W-1:0];
        REG_COUNT:  partition_count <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Read tracking: the data for an address issued now is evaluated next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == S_SCAN) && (issued != n_cur);
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= scan_addr;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rover <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_LOAD) begin
              res_status <= ST_LOADED;
              res_index  <= '0;
              state      <= S_DONE;
            end else if (n_act == '0) begin
              res_status <= ST_NOFIT;
              res_index  <= '0;
              state      <= S_DONE;
            end else begin
              want      <= amount;
              n_cur     <= n_act;
              scan_addr <= scan_start;
              issued    <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issued != n_cur) begin
            scan_addr <= scan_addr_next;
            issued    <= issued + CNT_W'(1);
          end else if (!pend) begin
            if (found) begin
              state <= S_MARK;
            end else begin
              res_status <= ST_NOFIT;
              res_index  <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_MARK: begin
          if (policy == POL_NEXT) begin
            rover <= (pick_inc >= n_cur) ? '0 : ADDR_W'(pick_inc);
          end
          res_status <= ST_PLACED;
          res_index  <= INDEX_W'(pick_idx);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: one beat waits here while the next item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      status       <= res_status;
      chosen_index <= res_index;
    end
  end

endmodule

// ----- verif/placement_ledger_pkg.sv -----
// Scoreboard for the fit placement allocator test: a predictor of the
// partition table and the queue of results it expects. Depends on fpa_pkg.
`timescale 1ns / 100ps

package placement_ledger_pkg;
  import fpa_pkg::*;

  // Table depth of the instance under test and the cap on printed mismatch reports.
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
  } outcome_t;

  class placement_ledger;
    bit [AMOUNT_W-1:0] size_tbl [TABLE_DEPTH];
    bit                taken [TABLE_DEPTH];
    bit [INDEX_W-1:0]  rover;
    bit [POLICY_W-1:0] policy;
    bit [COUNT_W-1:0]  count_reg;
    outcome_t          pending [$];
    int                mismatches;

    function new();
      foreach (size_tbl[i]) begin
        size_tbl[i] = '0;
        taken[i] = 1'b0;
      end
      rover = '0;
      policy = POL_FIRST;
      count_reg = '0;
      mismatches = 0;
    endfunction

    // Mirror of a register write seen at the configuration port.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
      if (idx == REG_POLICY) begin
        policy = data[POLICY_W-1:0];
      end else begin
        count_reg = data;
      end
    endfunction

    // A count above the table depth acts as the full table.
    function int active_count();
      return (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    endfunction

    // Chooses a free partition large enough for want, or -1 when none fits.
    function int pick_partition(bit [AMOUNT_W-1:0] want);
      int n;
      int j;
      int pick;
      int left;
      int best;
      n = active_count();
      pick = -1;
      best = 0;
      if (n == 0) begin
        return -1;
      end
      // Next fit scans from the rover once around the active entries.
      if (policy == POL_NEXT) begin
        j = (int'(rover) < n) ? int'(rover) : 0;
        for (int i = 0; i < n; i++) begin
          if (!taken[j] && size_tbl[j] >= want) begin
            return j;
          end
          j = (j + 1 >= n) ? 0 : j + 1;
        end
        return -1;
      end
      // The other policies walk up from index zero; ties keep the lower index.
      for (int i = 0; i < n; i++) begin
        if (taken[i] || size_tbl[i] < want) begin
          continue;
        end
        if (policy == POL_FIRST) begin
          return i;
        end
        left = int'(size_tbl[i]) - int'(want);
        if (pick < 0 || (policy == POL_BEST && left < best) ||
            (policy == POL_WORST && left > best)) begin
          pick = i;
          best = left;
        end
      end
      return pick;
    endfunction

    // Updates the table for an accepted item beat and queues its result.
    function void note_item(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                            logic [AMOUNT_W-1:0] amt);
      outcome_t o;
      int c;
      int n;
      o.index = '0;
      if (func == FUNC_LOAD) begin
        size_tbl[idx] = amt;
        taken[idx] = 1'b0;
        o.status = ST_LOADED;
      end else begin
        c = pick_partition(amt);
        if (c < 0) begin
          o.status = ST_NOFIT;
        end else begin
          n = active_count();
          taken[c] = 1'b1;
          if (policy == POL_NEXT) begin
            rover = (c + 1 >= n) ? '0 : INDEX_W'(c + 1);
          end
          o.status = ST_PLACED;
          o.index = INDEX_W'(c);
        end
      end
      pending.push_back(o);
    endfunction

    // Compares a result beat with the oldest expectation.
    function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] index);
      outcome_t o;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result beat: status %0d index %0d", $realtime,
                   status, index);
        end
        return;
      end
      o = pending.pop_front();
      if (status !== o.status || index !== o.index) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result mismatch: expected status %0d index %0d, got status %0d index %0d",
                   $realtime, o.status, o.index, status, index);
        end
      end
    endfunction
  endclass

endpackage

// ----- verif/fit_placement_allocator_test.sv -----
// Self-checking test of fit_placement_allocator: directed placements, then
// random loads and requests under all policies. Depends on fpa_pkg and the ledger.
`timescale 1ns / 100ps

module fit_placement_allocator_test;
  import fpa_pkg::*;
  import placement_ledger_pkg::*;

  localparam int RANDOM_ITEMS  = 1250;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PERCENT  = 23;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   part_index;
  logic [AMOUNT_W-1:0]  amount;
  logic                 result_valid;
  logic                 result_stall;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   chosen_index;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;

  placement_ledger ledger;
  logic            stall_free;
  int              quiet_cycles;

  fit_placement_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .part_index   (part_index),
    .amount       (amount),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .chosen_index (chosen_index),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, except during the stall-free stretch.
  always @(negedge clk) begin
    result_stall <= !rst && !stall_free && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Every accepted result beat is checked against the predicted one.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      ledger.check_result(status, chosen_index);
    end
  end

  // Count cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        cfg_write_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst === 1'b0);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Sends one item beat, after a random gap outside the stall-free stretch, and notes it once accepted.
  task automatic put_item(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                          input logic [AMOUNT_W-1:0] amt);
    while (!stall_free && $urandom_range(0, 99) < IDLE_PERCENT) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    func <= f;
    part_index <= idx;
    amount <= amt;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    ledger.note_item(f, idx, amt);
  endtask

  // Holds the item port idle until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    ledger.write_register(idx, data);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase;
    int len;
    int n;
    int free_cnt;
    int r;
    int base;
    bit is_load;
    logic [POLICY_W-1:0] pol;
    logic [COUNT_W-1:0]  cnt;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;

    ledger = new();
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    func = FUNC_LOAD;
    part_index = '0;
    amount = '0;
    result_stall = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = '0;
    stall_free = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With a count of zero every request misses.
    put_item(FUNC_REQUEST, 4'hF, 16'h0000);
    settle();
    set_reg(REG_COUNT, 5'd4);
    set_reg(REG_POLICY, COUNT_W'(POL_FIRST));
    put_item(FUNC_LOAD, 4'd0, 16'd100);
    put_item(FUNC_LOAD, 4'd1, 16'hFFFF);
    put_item(FUNC_LOAD, 4'd2, 16'd100);
    put_item(FUNC_LOAD, 4'd3, 16'd0);
    put_item(FUNC_REQUEST, 4'd0, 16'd60);
    settle();

    // Best fit prefers an exact fit, worst fit the largest leftover.
    set_reg(REG_POLICY, COUNT_W'(POL_BEST));
    put_item(FUNC_REQUEST, 4'd0, 16'd0);
    put_item(FUNC_REQUEST, 4'd0, 16'd100);
    settle();
    set_reg(REG_POLICY, COUNT_W'(POL_WORST));
    put_item(FUNC_REQUEST, 4'd0, 16'd0);
    put_item(FUNC_REQUEST, 4'd0, 16'd0);
    put_item(FUNC_LOAD, 4'd0, 16'd7);
    put_item(FUNC_LOAD, 4'd2, 16'd7);
    put_item(FUNC_REQUEST, 4'd0, 16'd7);
    settle();
    set_reg(REG_POLICY, COUNT_W'(POL_BEST));
    put_item(FUNC_REQUEST, 4'd0, 16'd7);
    settle();

    // Next fit walks from the rover and wraps at the count.
    set_reg(REG_POLICY, COUNT_W'(POL_NEXT));
    put_item(FUNC_LOAD, 4'd1, 16'hFFFF);
    put_item(FUNC_LOAD, 4'd3, 16'd0);
    put_item(FUNC_REQUEST, 4'd0, 16'd0);
    put_item(FUNC_REQUEST, 4'd0, 16'd0);
    put_item(FUNC_LOAD, 4'd0, 16'd5);
    put_item(FUNC_REQUEST, 4'd0, 16'd1);

    // Fill the whole table so that any count reads only loaded entries.
    sent = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      put_item(FUNC_LOAD, INDEX_W'(i), AMOUNT_W'($urandom_range(0, 65535)));
      sent++;
    end

    // Random phases, each under one policy and count, separated by a drain.
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: begin
          pol = POL_FIRST;
          cnt = 5'd16;
        end
        1: begin
          pol = POL_NEXT;
          cnt = 5'd31;
        end
        2: begin
          pol = POL_BEST;
          cnt = 5'd0;
        end
        3: begin
          pol = POL_WORST;
          cnt = 5'd1;
        end
        default: begin
          pol = POLICY_W'($urandom_range(0, 3));
          r = $urandom_range(0, 99);
          if (r < 55) begin
            cnt = COUNT_W'($urandom_range(1, 8));
          end else if (r < 85) begin
            cnt = COUNT_W'($urandom_range(9, 16));
          end else if (r < 95) begin
            cnt = COUNT_W'($urandom_range(17, 31));
          end else begin
            cnt = '0;
          end
        end
      endcase
      set_reg(REG_POLICY, COUNT_W'(pol));
      set_reg(REG_COUNT, cnt);
      stall_free = (phase == 4 || phase == 5);
      len = $urandom_range(60, 110);
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        n = ledger.active_count();
        free_cnt = 0;
        for (int i = 0; i < n; i++) begin
          if (!ledger.taken[i]) begin
            free_cnt++;
          end
        end
        if (n == 0) begin
          is_load = ($urandom_range(0, 99) < 40);
        end else if (free_cnt == 0) begin
          is_load = ($urandom_range(0, 99) < 60);
        end else begin
          is_load = ($urandom_range(0, 99) < 30);
        end
        r = $urandom_range(0, 99);
        if (is_load) begin
          // Mostly refill active entries; a small size set makes ties common.
          if (n > 0 && $urandom_range(0, 99) < 70) begin
            idx = INDEX_W'($urandom_range(0, n - 1));
          end else begin
            idx = INDEX_W'($urandom_range(0, 15));
          end
          if (r < 10) begin
            amt = '0;
          end else if (r < 20) begin
            amt = '1;
          end else if (r < 50) begin
            amt = AMOUNT_W'(16 * $urandom_range(1, 4));
          end else begin
            amt = AMOUNT_W'($urandom_range(0, 65535));
          end
          put_item(FUNC_LOAD, idx, amt);
        end else begin
          // Requests aim at or near existing sizes so that fits are close.
          idx = INDEX_W'($urandom_range(0, 15));
          base = (n > 0) ? int'(ledger.size_tbl[$urandom_range(0, n - 1)]) : 0;
          if (r < 35) begin
            amt = AMOUNT_W'(base);
          end else if (r < 55) begin
            base = base + $urandom_range(0, 6) - 3;
            amt = (base < 0) ? '0 : (base > 65535) ? '1 : AMOUNT_W'(base);
          end else if (r < 65) begin
            amt = '0;
          end else if (r < 70) begin
            amt = '1;
          end else if (r < 85) begin
            amt = AMOUNT_W'($urandom_range(0, 80));
          end else begin
            amt = AMOUNT_W'($urandom_range(0, 65535));
          end
          put_item(FUNC_REQUEST, idx, amt);
        end
        sent++;
      end
      phase++;
    end

    settle();
    stall_free = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
